@@ src/dmac_pkg.sv @@
`timescale 1ns / 1ps
package dmac_pkg;

   localparam int PRICE_W   = 32;
   localparam int WIN_W     = 11;
   localparam int DIR_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [WIN_W-1:0] COUNT_MAX    = 11'h7FF;
   localparam logic [WIN_W-1:0] SHORT_RESET  = 11'd1;
   localparam logic [WIN_W-1:0] LONG_RESET   = 11'd60;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WINDOW  = 2'd1;

   localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_ABOVE = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BELOW = 2'd2;

   // shared serial divider and multiplier widths
   localparam int DIV_DVD_W = 64;
   localparam int DIV_DVS_W = 34;
   localparam int DIV_CNT_W = 7;
   localparam int MUL_W     = 32;
   localparam int MUL_CNT_W = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_SHORT,
      ST_RD_LONG,
      ST_WRITE,
      ST_SWEEP,
      ST_DIV_SHORT,
      ST_DIV_LONG,
      ST_MUL,
      ST_DIV_CROSS,
      ST_FINISH
   } state_type;

endpackage

@@ src/dmac_if.sv @@
`timescale 1ns / 1ps
interface dmac_req_if;
   import dmac_pkg::*;
   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] sample_price;
   logic               sample_present;
   modport source (output valid, output sample_price, output sample_present, input ready);
   modport sink   (input valid, input sample_price, input sample_present, output ready);
endinterface

interface dmac_rsp_if;
   import dmac_pkg::*;
   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] short_average;
   logic [PRICE_W-1:0] long_average;
   logic [DIR_W-1:0]   cross_direction;
   logic [PRICE_W-1:0] cross_price;
   logic               enough_history;
   modport source (output valid, output short_average, output long_average,
                   output cross_direction, output cross_price, output enough_history,
                   input ready);
   modport sink   (input valid, input short_average, input long_average,
                   input cross_direction, input cross_price, input enough_history,
                   output ready);
endinterface

interface dmac_csr_if;
   import dmac_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WIN_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/dmac_mul.sv @@
`timescale 1ns / 1ps
module dmac_mul import dmac_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MUL_W-1:0]     mult_a,
   input  logic [MUL_W-1:0]     mult_b,
   output logic                 done,
   output logic [2*MUL_W-1:0]   product
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_W-1:0]     a_ff, a_in;
   logic [2*MUL_W:0]     acc_ff, acc_in;
   logic [MUL_W:0]       part;

   // one multiplier bit per cycle, shift-add from the low end
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      part    = {1'b0, acc_ff[2*MUL_W-1:MUL_W]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MUL_CNT_W'(MUL_W);
         a_in    = mult_a;
         acc_in  = {(MUL_W+1)'(0), mult_b};
      end else if (busy_ff) begin
         acc_in = {1'b0, part, acc_ff[MUL_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff[2*MUL_W-1:0];

endmodule

@@ src/dmac_div.sv @@
`timescale 1ns / 1ps
module dmac_div import dmac_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_DVD_W-1:0] dividend,
   input  logic [DIV_DVS_W-1:0] divisor,
   input  logic [DIV_CNT_W-1:0] steps,
   output logic                 done,
   output logic [DIV_DVD_W-1:0] quotient,
   output logic                 rem_nz
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DVS_W-1:0] dvs_ff, dvs_in;
   logic [DIV_DVS_W-1:0] rem_ff, rem_in;
   logic [DIV_DVD_W-1:0] dq_ff, dq_in;
   logic [DIV_DVS_W+1:0] trial;

   // restoring division, one quotient bit per cycle; dividend arrives left aligned
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      trial   = {1'b0, rem_ff, dq_ff[DIV_DVD_W-1]} - {2'b00, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         dvs_in  = divisor;
         rem_in  = '0;
         dq_in   = dividend;
      end else if (busy_ff) begin
         if (!trial[DIV_DVS_W+1]) begin
            rem_in = trial[DIV_DVS_W-1:0];
         end else begin
            rem_in = {rem_ff[DIV_DVS_W-2:0], dq_ff[DIV_DVD_W-1]};
         end
         dq_in  = {dq_ff[DIV_DVD_W-2:0], !trial[DIV_DVS_W+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;
   assign rem_nz   = (rem_ff != '0);

endmodule

@@ src/dual_moving_average_crossover.sv @@
`timescale 1ns / 1ps
// Each request passes through the serial divider (three divisions, one bit a cycle) and the
// serial multiplier; a leading absent request skips the history access.
// The first stored request after a window write also sweeps the history, one entry a cycle.
// Throughput: one request at a time; the next is taken while the last result waits.
// Reset (synchronous, active high) clears counts, sums and windows to 1 and 60; history is
// left unwritten.
module dual_moving_average_crossover import dmac_pkg::*; #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic        clock,
   input  logic        reset,
   dmac_req_if.sink    req_chan,
   dmac_rsp_if.source  rsp_chan,
   dmac_csr_if.sink    csr_chan
);

   localparam int IW    = $clog2(MAX_WINDOW);
   localparam int SUM_W = PRICE_W + $clog2(MAX_WINDOW + 1);
   localparam logic [IW:0] MAXW_I = (IW+1)'(MAX_WINDOW);
   localparam logic [16:0] MAXW_L = 17'(MAX_WINDOW);

   // step back span entries around the circular history
   function automatic logic [IW-1:0] back_idx(input logic [IW-1:0] base,
                                              input logic [WIN_W:0] span);
      logic [IW:0] t;
      t = {1'b0, base} + MAXW_I - (IW+1)'(span);
      if (t >= MAXW_I) t = t - MAXW_I;
      return t[IW-1:0];
   endfunction

   function automatic logic tracked(input logic [WIN_W-1:0] w);
      return (w != '0) && (17'(w) <= MAXW_L);
   endfunction

   state_type state_ff, state_in;

   logic [PRICE_W-1:0] price_ff, price_in;
   logic [IW-1:0]      wi_ff, wi_in;
   logic [WIN_W-1:0]   pc_ff, pc_in, tc_ff, tc_in, pc_new, tc_new;
   logic               seen_ff, seen_in;
   logic [WIN_W-1:0]   ws_ff, ws_in, wl_ff, wl_in;
   logic               dirty_ff, dirty_in;
   logic [SUM_W-1:0]   sum_s_ff, sum_s_in, sum_l_ff, sum_l_in;
   logic [PRICE_W-1:0] old_s_ff, old_s_in;
   logic [WIN_W:0]     k_ff, k_in, rk_ff, rk_in;
   logic [WIN_W-1:0]   ns_ff, ns_in, nl_ff, nl_in, nmax;
   logic               rv_ff, rv_in, issue;
   logic [PRICE_W-1:0] sa_ff, sa_in, la_ff, la_in, ps_ff, ps_in, pl_ff, pl_in;
   logic               started_ff, started_in;
   logic               neg_ff, neg_in, special_ff, special_in;

   logic               rv_out_ff, rv_out_in;
   logic [PRICE_W-1:0] o_sa_ff, o_sa_in, o_la_ff, o_la_in, o_cp_ff, o_cp_in;
   logic [DIR_W-1:0]   o_dir_ff, o_dir_in;
   logic               o_en_ff, o_en_in;

   // history memory
   logic [PRICE_W-1:0] hist_mem_ff [MAX_WINDOW];
   logic [PRICE_W-1:0] rdata_ff;
   logic [IW-1:0]      raddr, waddr;
   logic               we;

   // shared units
   logic                 div_start, div_done, div_rnz;
   logic [DIV_DVD_W-1:0] div_dvd, div_q;
   logic [DIV_DVS_W-1:0] div_dvs;
   logic [DIV_CNT_W-1:0] div_steps;
   logic                 mul_start, mul_done;
   logic [2*MUL_W-1:0]   mul_p;

   // crossing terms
   logic signed [PRICE_W+2:0] dif, difx, den, stp;
   logic [PRICE_W+2:0]        den_mag, dif_mag, stp_mag;
   logic [DIV_DVD_W-1:0]      lim;
   logic [DIV_DVD_W:0]        q_up;
   logic                      use_s, use_l;

   dmac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_q),
      .rem_nz   (div_rnz)
   );

   dmac_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mult_a  (stp_mag[MUL_W-1:0]),
      .mult_b  (dif_mag[MUL_W-1:0]),
      .done    (mul_done),
      .product (mul_p)
   );

   always_ff @(posedge clock) begin
      if (we) hist_mem_ff[waddr] <= price_ff;
      rdata_ff <= hist_mem_ff[raddr];
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign pc_new = (pc_ff == COUNT_MAX) ? pc_ff : pc_ff + 1'b1;
   assign tc_new = (tc_ff == COUNT_MAX) ? tc_ff : tc_ff + 1'b1;
   assign nmax   = (ns_ff > nl_ff) ? ns_ff : nl_ff;
   assign issue  = (k_ff <= {1'b0, nmax});
   assign use_s  = seen_ff && (ws_ff > 11'd1) && tracked(ws_ff) && (pc_ff >= ws_ff);
   assign use_l  = seen_ff && (wl_ff > 11'd1) && tracked(wl_ff) && (pc_ff >= wl_ff);

   // signed terms of the crossing interpolation
   always_comb begin
      dif     = $signed({3'b000, ps_ff}) - $signed({3'b000, pl_ff});
      difx    = $signed({3'b000, la_ff}) - $signed({3'b000, sa_ff});
      den     = dif + difx;
      stp     = $signed({3'b000, sa_ff}) - $signed({3'b000, ps_ff});
      den_mag = den[PRICE_W+2] ? -den : den;
      dif_mag = dif[PRICE_W+2] ? -dif : dif;
      stp_mag = stp[PRICE_W+2] ? -stp : stp;
      lim     = DIV_DVD_W'(32'hFFFF_FFFF - ps_ff);
      q_up    = {1'b0, div_q} + (DIV_DVD_W+1)'(div_rnz);
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      price_in   = price_ff;
      wi_in      = wi_ff;
      pc_in      = pc_ff;
      tc_in      = tc_ff;
      seen_in    = seen_ff;
      ws_in      = ws_ff;
      wl_in      = wl_ff;
      dirty_in   = dirty_ff;
      sum_s_in   = sum_s_ff;
      sum_l_in   = sum_l_ff;
      old_s_in   = old_s_ff;
      k_in       = k_ff;
      rk_in      = rk_ff;
      ns_in      = ns_ff;
      nl_in      = nl_ff;
      rv_in      = 1'b0;
      sa_in      = sa_ff;
      la_in      = la_ff;
      ps_in      = ps_ff;
      pl_in      = pl_ff;
      started_in = started_ff;
      neg_in     = neg_ff;
      special_in = special_ff;
      rv_out_in  = rv_out_ff;
      o_sa_in    = o_sa_ff;
      o_la_in    = o_la_ff;
      o_cp_in    = o_cp_ff;
      o_dir_in   = o_dir_ff;
      o_en_in    = o_en_ff;
      raddr      = wi_ff;
      waddr      = wi_ff;
      we         = 1'b0;
      div_start  = 1'b0;
      div_dvd    = {sum_s_ff, {(DIV_DVD_W-SUM_W){1'b0}}};
      div_dvs    = DIV_DVS_W'(ws_ff);
      div_steps  = DIV_CNT_W'(SUM_W);
      mul_start  = 1'b0;

      // drop the result once taken
      if (rsp_chan.ready) rv_out_in = 1'b0;

      // register writes
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SHORT_WINDOW: begin
               ws_in    = csr_chan.data;
               dirty_in = 1'b1;
            end
            CSR_LONG_WINDOW: begin
               wl_in    = csr_chan.data;
               dirty_in = 1'b1;
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               price_in = req_chan.sample_price;
               state_in = (req_chan.sample_present | seen_ff) ? ST_RD_SHORT : ST_DIV_SHORT;
            end
         end
         ST_RD_SHORT: begin
            raddr    = back_idx(wi_ff, {1'b0, ws_ff});
            state_in = ST_RD_LONG;
         end
         ST_RD_LONG: begin
            old_s_in = rdata_ff;
            raddr    = back_idx(wi_ff, {1'b0, wl_ff});
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // store, then slide both sums by one entry
            we      = 1'b1;
            seen_in = 1'b1;
            pc_in   = pc_new;
            wi_in   = (wi_ff == IW'(MAX_WINDOW - 1)) ? '0 : wi_ff + 1'b1;
            sum_s_in = sum_s_ff + SUM_W'(price_ff)
                       - ((tracked(ws_ff) && pc_ff >= ws_ff) ? SUM_W'(old_s_ff) : '0);
            sum_l_in = sum_l_ff + SUM_W'(price_ff)
                       - ((tracked(wl_ff) && pc_ff >= wl_ff) ? SUM_W'(rdata_ff) : '0);
            if (dirty_ff) begin
               // a window changed: rebuild both sums from history
               sum_s_in = '0;
               sum_l_in = '0;
               ns_in    = tracked(ws_ff) ? ((pc_new < ws_ff) ? pc_new : ws_ff) : '0;
               nl_in    = tracked(wl_ff) ? ((pc_new < wl_ff) ? pc_new : wl_ff) : '0;
               k_in     = (WIN_W+1)'(1);
               dirty_in = 1'b0;
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_DIV_SHORT;
            end
         end
         ST_SWEEP: begin
            raddr = back_idx(wi_ff, k_ff);
            rv_in = issue;
            rk_in = k_ff;
            if (issue) k_in = k_ff + 1'b1;
            if (rv_ff) begin
               if (rk_ff <= {1'b0, ns_ff}) sum_s_in = sum_s_ff + SUM_W'(rdata_ff);
               if (rk_ff <= {1'b0, nl_ff}) sum_l_in = sum_l_ff + SUM_W'(rdata_ff);
            end
            if (!issue && !rv_ff) state_in = ST_DIV_SHORT;
         end
         ST_DIV_SHORT: begin
            div_start  = !started_ff;
            started_in = (started_ff | div_start) & !div_done;
            if (div_done) begin
               sa_in    = use_s ? div_q[PRICE_W-1:0] : price_ff;
               state_in = ST_DIV_LONG;
            end
         end
         ST_DIV_LONG: begin
            div_dvd    = {sum_l_ff, {(DIV_DVD_W-SUM_W){1'b0}}};
            div_dvs    = DIV_DVS_W'(wl_ff);
            div_start  = !started_ff;
            started_in = (started_ff | div_start) & !div_done;
            if (div_done) begin
               la_in    = use_l ? div_q[PRICE_W-1:0] : price_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_start  = !started_ff;
            started_in = (started_ff | mul_start) & !mul_done;
            neg_in     = (stp[PRICE_W+2] ^ dif[PRICE_W+2]) ^ den[PRICE_W+2];
            special_in = (den == '0) || (dif == '0) || (stp == '0);
            if (mul_done) state_in = ST_DIV_CROSS;
         end
         ST_DIV_CROSS: begin
            div_dvd    = mul_p;
            div_dvs    = den_mag[DIV_DVS_W-1:0];
            div_steps  = DIV_CNT_W'(DIV_DVD_W);
            div_start  = !started_ff;
            started_in = (started_ff | div_start) & !div_done;
            if (div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rv_out_ff || rsp_chan.ready) begin
               rv_out_in = 1'b1;
               o_sa_in   = sa_ff;
               o_la_in   = la_ff;
               o_en_in   = (tc_new > ws_ff) && (tc_new > wl_ff);
               o_dir_in  = DIR_NONE;
               o_cp_in   = '0;
               if (tc_ff != '0) begin
                  if (dif[PRICE_W+2] && difx[PRICE_W+2]) begin
                     o_dir_in = DIR_ABOVE;
                  end else if (!dif[PRICE_W+2] && dif != '0 &&
                               !difx[PRICE_W+2] && difx != '0) begin
                     o_dir_in = DIR_BELOW;
                  end
                  if (special_ff) begin
                     o_cp_in = ps_ff;
                  end else if (!neg_ff) begin
                     o_cp_in = (div_q > lim) ? 32'hFFFF_FFFF : ps_ff + div_q[PRICE_W-1:0];
                  end else begin
                     o_cp_in = (q_up > (DIV_DVD_W+1)'(ps_ff)) ? '0
                               : ps_ff - q_up[PRICE_W-1:0];
                  end
               end
               tc_in    = tc_new;
               ps_in    = sa_ff;
               pl_in    = la_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wi_ff      <= '0;
         pc_ff      <= '0;
         tc_ff      <= '0;
         seen_ff    <= 1'b0;
         ws_ff      <= SHORT_RESET;
         wl_ff      <= LONG_RESET;
         dirty_ff   <= 1'b0;
         sum_s_ff   <= '0;
         sum_l_ff   <= '0;
         ps_ff      <= '0;
         pl_ff      <= '0;
         started_ff <= 1'b0;
         rv_ff      <= 1'b0;
         rv_out_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wi_ff      <= wi_in;
         pc_ff      <= pc_in;
         tc_ff      <= tc_in;
         seen_ff    <= seen_in;
         ws_ff      <= ws_in;
         wl_ff      <= wl_in;
         dirty_ff   <= dirty_in;
         sum_s_ff   <= sum_s_in;
         sum_l_ff   <= sum_l_in;
         ps_ff      <= ps_in;
         pl_ff      <= pl_in;
         started_ff <= started_in;
         rv_ff      <= rv_in;
         rv_out_ff  <= rv_out_in;
      end
      price_ff   <= price_in;
      old_s_ff   <= old_s_in;
      k_ff       <= k_in;
      rk_ff      <= rk_in;
      ns_ff      <= ns_in;
      nl_ff      <= nl_in;
      sa_ff      <= sa_in;
      la_ff      <= la_in;
      neg_ff     <= neg_in;
      special_ff <= special_in;
      o_sa_ff    <= o_sa_in;
      o_la_ff    <= o_la_in;
      o_cp_ff    <= o_cp_in;
      o_dir_ff   <= o_dir_in;
      o_en_ff    <= o_en_in;
   end

   assign rsp_chan.valid           = rv_out_ff;
   assign rsp_chan.short_average   = o_sa_ff;
   assign rsp_chan.long_average    = o_la_ff;
   assign rsp_chan.cross_direction = o_dir_ff;
   assign rsp_chan.cross_price     = o_cp_ff;
   assign rsp_chan.enough_history  = o_en_ff;

endmodule

@@ src/dmac_checker.sv @@
`timescale 1ns / 1ps
module dmac_checker import dmac_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PRICE_W-1:0] short_average,
   input logic [PRICE_W-1:0] long_average,
   input logic [DIR_W-1:0]   cross_direction,
   input logic [PRICE_W-1:0] cross_price
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(short_average)
         && $stable(cross_price) && $stable(cross_direction))
      else $error("stalled result changed");

   // one request at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cross_direction == DIR_NONE || cross_direction == DIR_ABOVE
         || cross_direction == DIR_BELOW)
      else $error("bad cross direction");

   a_above: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cross_direction == DIR_ABOVE |-> short_average > long_average)
      else $error("upward cross with short below long");

   a_below: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cross_direction == DIR_BELOW |-> short_average < long_average)
      else $error("downward cross with short above long");

endmodule

bind dual_moving_average_crossover dmac_checker u_dmac_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .short_average   (rsp_chan.short_average),
   .long_average    (rsp_chan.long_average),
   .cross_direction (rsp_chan.cross_direction),
   .cross_price     (rsp_chan.cross_price)
);
